// ----- src/checksummed_sentence_parser_macros.svh -----
// Assertion macros for the sentence parser core (csp_core).
`ifndef CHECKSUMMED_SENTENCE_PARSER_MACROS_SVH
`define CHECKSUMMED_SENTENCE_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CSP_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CSP_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- src/csp_pkg.sv -----
// Shared constants and types of the checksummed sentence parser.
package csp_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned STAT_W = 3;

	localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd64;

	localparam logic [BYTE_W-1:0] CH_START = "$";
	localparam logic [BYTE_W-1:0] CH_STAR = "*";
	localparam logic [BYTE_W-1:0] CH_NL = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_COMMA = ",";

	localparam logic [23:0] ID_CHA = "CHA";
	localparam logic [23:0] ID_HIT = "HIT";
	localparam logic [23:0] ID_DET = "DET";
	localparam logic [23:0] ID_COO = "COO";

	localparam logic [STAT_W-1:0] ST_WAITING = 3'd0;
	localparam logic [STAT_W-1:0] ST_GOOD = 3'd1;
	localparam logic [STAT_W-1:0] ST_FAIL = 3'd2;
	localparam logic [STAT_W-1:0] ST_CHA = 3'd3;
	localparam logic [STAT_W-1:0] ST_HIT = 3'd4;
	localparam logic [STAT_W-1:0] ST_DET = 3'd5;
	localparam logic [STAT_W-1:0] ST_COO = 3'd6;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value_one;
		logic [VAL_W-1:0]  value_two;
		logic [BYTE_W-1:0] value_three;
	} result_t;

endpackage

// ----- src/checksummed_sentence_parser.sv -----
// Top level of the checksummed sentence parser: channels, stage registers and configuration.
//
// Usage:
//   The in channel (in_valid/in_ready/in_byte) takes one character per item. Every
//   accepted item yields exactly one result on the out channel (out_valid/out_ready,
//   status, value_one, value_two, value_three), in order.
//   An accepted item sits in the input register until the result register is free or
//   being drained, is then parsed against the sentence state and lands in the result
//   register, which drives out_valid. Throughput is one item per cycle while the
//   receiver does not stall, set by the single pass from the input register through
//   the parse logic to the result register.
//   When the receiver stalls, the result register holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
//   The cfg channel (cfg_valid/cfg_ready/cfg_data) writes max_payload, the longest
//   payload accepted; cfg_ready is always high. Write it only while no item is in flight.
//   Reset (arst_n low) empties both registers, returns the parser to waiting for '$'
//   and sets max_payload to 64.
module checksummed_sentence_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [csp_pkg::BYTE_W-1:0] in_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [csp_pkg::STAT_W-1:0] status,
	output logic [csp_pkg::VAL_W-1:0]  value_one,
	output logic [csp_pkg::VAL_W-1:0]  value_two,
	output logic [csp_pkg::BYTE_W-1:0] value_three,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [csp_pkg::BYTE_W-1:0] cfg_data
);
	import csp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic [BYTE_W-1:0] max_payload_q;
	logic              advance;

	// parse the held item once the result register is free or being drained
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	csp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.byte_s1     (byte_s1),
		.max_payload (max_payload_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				max_payload_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign value_one = res_s2.value_one;
	assign value_two = res_s2.value_two;
	assign value_three = res_s2.value_three;

endmodule

// ----- src/csp_dec_acc.sv -----
// Saturating decimal accumulate: value * 10 + digit, clamped to all ones.
module csp_dec_acc (
	input  logic [csp_pkg::VAL_W-1:0] acc,
	input  logic [3:0]                digit,
	output logic [csp_pkg::VAL_W-1:0] acc_next
);
	import csp_pkg::*;

	logic [VAL_W+3:0] wide;

	// x10 as x8 + x2
	assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VAL_W{1'b0}}, digit};
	assign acc_next = (wide[VAL_W+3:VAL_W] != 4'd0) ? {VAL_W{1'b1}} : wide[VAL_W-1:0];

endmodule

// ----- src/csp_core.sv -----
// Sentence state and the per-byte framing, checksum and token logic.
`include "checksummed_sentence_parser_macros.svh"

module csp_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [csp_pkg::BYTE_W-1:0] byte_s1,
	input  logic [csp_pkg::BYTE_W-1:0] max_payload,
	output csp_pkg::result_t           res
);
	import csp_pkg::*;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_REC,
		PH_HEX1,
		PH_HEX2,
		PH_NL
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] id_q [3];
	logic [BYTE_W-1:0] id_d [3];
	logic [2:0]        tidx_q, tidx_d;
	logic [1:0]        flags_q, flags_d;
	logic [VAL_W-1:0]  tok_q [3];
	logic [VAL_W-1:0]  tok_d [3];

	logic [2:0]       tidx_new;
	logic [1:0]       k;
	logic             in_win;
	logic             is_digit;
	logic [VAL_W-1:0] acc_in;
	logic [VAL_W-1:0] acc_out;
	logic             hex_ok;
	logic [3:0]       hex_val;
	logic [1:0]       flags_v;
	logic [23:0]      id_word;

	// a non-comma byte outside a token opens the next token
	assign tidx_new = (!flags_q[0] && byte_s1 != CH_COMMA && tidx_q != 3'd7) ?
		tidx_q + 3'd1 : tidx_q;
	assign in_win = (tidx_new >= 3'd2) && (tidx_new <= 3'd4);
	assign k = 2'(tidx_new - 3'd2);
	assign is_digit = (byte_s1 >= "0") && (byte_s1 <= "9");
	assign id_word = {id_q[0], id_q[1], id_q[2]};

	always_comb begin
		case (k)
			2'd0: acc_in = tok_q[0];
			2'd1: acc_in = tok_q[1];
			2'd2: acc_in = tok_q[2];
			default: acc_in = '0;
		endcase
	end

	csp_dec_acc u_acc (
		.acc      (acc_in),
		.digit    (4'(byte_s1 - "0")),
		.acc_next (acc_out)
	);

	always_comb begin
		if (is_digit) begin
			hex_ok = 1'b1;
			hex_val = 4'(byte_s1 - "0");
		end else if (byte_s1 >= "a" && byte_s1 <= "f") begin
			hex_ok = 1'b1;
			hex_val = 4'(byte_s1 - 8'h57);
		end else begin
			hex_ok = 1'b0;
			hex_val = 4'd0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		xor_d = xor_q;
		sum_d = sum_q;
		id_d = id_q;
		tidx_d = tidx_q;
		flags_d = flags_q;
		tok_d = tok_q;
		flags_v = flags_q;
		res = '0;
		res.status = ST_WAITING;
		case (phase_q)
			PH_WAIT: begin
				if (byte_s1 == CH_START) begin
					cnt_d = '0;
					xor_d = '0;
					sum_d = '0;
					id_d = '{default: '0};
					tidx_d = '0;
					flags_d = '0;
					tok_d = '{default: '0};
					phase_d = PH_REC;
					res.status = ST_GOOD;
				end
			end
			PH_REC: begin
				if (byte_s1 == CH_STAR) begin
					phase_d = PH_HEX1;
					res.status = ST_GOOD;
				end else if (cnt_q >= max_payload) begin
					phase_d = PH_WAIT;
					res.status = ST_FAIL;
				end else begin
					xor_d = xor_q ^ byte_s1;
					if (cnt_q < 8'd3) begin
						id_d[cnt_q[1:0]] = byte_s1;
					end
					cnt_d = cnt_q + 8'd1;
					if (byte_s1 == CH_COMMA) begin
						flags_d = 2'b00;
					end else begin
						tidx_d = tidx_new;
						if (!flags_q[0]) begin
							flags_v = 2'b01;
						end
						if (in_win && !flags_v[1]) begin
							if (is_digit) begin
								tok_d[k] = acc_out;
							end else begin
								// first non-digit closes the value
								flags_v[1] = 1'b1;
							end
						end
						flags_d = flags_v;
					end
					res.status = ST_GOOD;
				end
			end
			PH_HEX1: begin
				if (!hex_ok) begin
					phase_d = PH_WAIT;
					res.status = ST_FAIL;
				end else begin
					sum_d = {hex_val, 4'd0};
					phase_d = PH_HEX2;
					res.status = ST_GOOD;
				end
			end
			PH_HEX2: begin
				if (!hex_ok || (sum_q | {4'd0, hex_val}) != xor_q) begin
					phase_d = PH_WAIT;
					res.status = ST_FAIL;
				end else begin
					sum_d = sum_q | {4'd0, hex_val};
					phase_d = PH_NL;
					res.status = ST_GOOD;
				end
			end
			PH_NL: begin
				phase_d = PH_WAIT;
				res.status = ST_FAIL;
				if (byte_s1 == CH_NL) begin
					if (id_word == ID_CHA) begin
						res.status = ST_CHA;
						res.value_one = tok_q[0];
						res.value_two = tok_q[1];
					end else if (id_word == ID_HIT) begin
						res.status = ST_HIT;
						res.value_one = {24'd0, tok_q[0][7:0]};
						res.value_two = {24'd0, tok_q[1][7:0]};
						res.value_three = tok_q[2][7:0];
					end else if (id_word == ID_DET) begin
						res.status = ST_DET;
						res.value_one = tok_q[0];
						res.value_two = tok_q[1];
					end else if (id_word == ID_COO) begin
						res.status = ST_COO;
						res.value_one = {24'd0, tok_q[0][7:0]};
						res.value_two = {24'd0, tok_q[1][7:0]};
					end
				end
			end
			default: begin
				phase_d = PH_WAIT;
				res.status = ST_FAIL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q <= '0;
			xor_q <= '0;
			sum_q <= '0;
			id_q <= '{default: '0};
			tidx_q <= '0;
			flags_q <= '0;
			tok_q <= '{default: '0};
		end else if (en) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			xor_q <= xor_d;
			sum_q <= sum_d;
			id_q <= id_d;
			tidx_q <= tidx_d;
			flags_q <= flags_d;
			tok_q <= tok_d;
		end
	end

	`CSP_ASSERT_NOW(a_wait_no_values, en && phase_q == PH_WAIT,
		res.value_one == '0 && res.value_two == '0 && res.value_three == '0,
		"values driven outside a completed sentence")
	`CSP_ASSERT_NOW(a_parsed_only_at_nl,
		en && (res.status == ST_CHA || res.status == ST_HIT ||
		res.status == ST_DET || res.status == ST_COO),
		phase_q == PH_NL, "parsed status outside newline phase")
	`CSP_ASSERT_NEXT(a_fail_returns_wait, en && res.status == ST_FAIL,
		phase_q == PH_WAIT, "failure did not return to waiting")
	`CSP_ASSERT_NOW(a_flags_ended_in_token, 1'b1, !(flags_q[1] && !flags_q[0]),
		"value-ended flag set outside a token")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the checksummed sentence parser with its own parse predictor.
`timescale 1ns / 100ps

module testbench;
	import csp_pkg::*;

	typedef logic [7:0] byte_list_t[$];
	typedef enum logic [2:0] {
		WAIT_START, IN_PAYLOAD, SUM_HIGH, SUM_LOW, WANT_NEWLINE
	} parse_phase_t;
	typedef enum {CLEAN, BAD_SUM_HIGH, BAD_SUM_LOW, WRONG_SUM, NO_NEWLINE, CUT_SHORT} flaw_t;

	class sentence_scoreboard;
		result_t expected_q[$];
		int mismatches;
		logic [7:0] max_len;
		parse_phase_t phase;
		logic [7:0] byte_count;
		logic [7:0] xor_sum;
		logic [7:0] rx_sum;
		logic [7:0] id_text[3];
		logic [2:0] field_no;
		bit in_field;
		bit field_done;
		logic [31:0] field_val[3];

		function new();
			mismatches = 0;
			max_len = MAX_PAYLOAD_RST;
			phase = WAIT_START;
			clear_sentence();
		endfunction

		function void clear_sentence();
			byte_count = '0;
			xor_sum = '0;
			rx_sum = '0;
			id_text = '{default: '0};
			field_no = '0;
			in_field = 0;
			field_done = 0;
			field_val = '{default: '0};
		endfunction

		// Bit 4 set marks a character that is not a lowercase hex digit.
		function logic [4:0] hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return {1'b0, 4'(c - "0")};
			if (c >= "a" && c <= "f")
				return {1'b0, 4'(c - "a" + 8'd10)};
			return 5'h10;
		endfunction

		function void take_payload(logic [7:0] c);
			logic [35:0] wide;
			int k;
			xor_sum ^= c;
			if (byte_count < 3)
				id_text[byte_count] = c;
			byte_count++;
			if (c == CH_COMMA) begin
				in_field = 0;
				field_done = 0;
				return;
			end
			if (!in_field) begin
				in_field = 1;
				field_done = 0;
				if (field_no < 7)
					field_no++;
			end
			// The identifier is field 1; fields 2..4 carry the values.
			if (field_no >= 2 && field_no <= 4 && !field_done) begin
				k = field_no - 2;
				if (c >= "0" && c <= "9") begin
					wide = {4'b0, field_val[k]} * 36'd10 + 36'(c - "0");
					field_val[k] = (wide > 36'hFFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
				end else begin
					field_done = 1;
				end
			end
		endfunction

		function void note_byte(logic [7:0] c);
			result_t r;
			logic [4:0] h;
			logic [23:0] id;
			r = '0;
			r.status = ST_WAITING;
			h = hex_digit(c);
			case (phase)
				WAIT_START: begin
					if (c == CH_START) begin
						clear_sentence();
						phase = IN_PAYLOAD;
						r.status = ST_GOOD;
					end
				end
				IN_PAYLOAD: begin
					if (c == CH_STAR) begin
						phase = SUM_HIGH;
						r.status = ST_GOOD;
					end else if (byte_count >= max_len) begin
						phase = WAIT_START;
						r.status = ST_FAIL;
					end else begin
						take_payload(c);
						r.status = ST_GOOD;
					end
				end
				SUM_HIGH: begin
					if (h[4]) begin
						phase = WAIT_START;
						r.status = ST_FAIL;
					end else begin
						rx_sum = {h[3:0], 4'h0};
						phase = SUM_LOW;
						r.status = ST_GOOD;
					end
				end
				SUM_LOW: begin
					if (h[4] || (rx_sum | {4'h0, h[3:0]}) != xor_sum) begin
						phase = WAIT_START;
						r.status = ST_FAIL;
					end else begin
						rx_sum = rx_sum | {4'h0, h[3:0]};
						phase = WANT_NEWLINE;
						r.status = ST_GOOD;
					end
				end
				WANT_NEWLINE: begin
					phase = WAIT_START;
					r.status = ST_FAIL;
					id = {id_text[0], id_text[1], id_text[2]};
					if (c == CH_NL) begin
						if (id == ID_CHA) begin
							r.status = ST_CHA;
							r.value_one = field_val[0];
							r.value_two = field_val[1];
						end else if (id == ID_HIT) begin
							r.status = ST_HIT;
							r.value_one = {24'h0, field_val[0][7:0]};
							r.value_two = {24'h0, field_val[1][7:0]};
							r.value_three = field_val[2][7:0];
						end else if (id == ID_DET) begin
							r.status = ST_DET;
							r.value_one = field_val[0];
							r.value_two = field_val[1];
						end else if (id == ID_COO) begin
							r.status = ST_COO;
							r.value_one = {24'h0, field_val[0][7:0]};
							r.value_two = {24'h0, field_val[1][7:0]};
						end
					end
				end
				default: begin
					phase = WAIT_START;
					r.status = ST_FAIL;
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 60)
					$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 60)
					$display("%0t: result expected none actual status %0d", $time, got.status);
				return;
			end
			want = expected_q.pop_front();
			report("status", 32'(want.status), 32'(got.status));
			report("value_one", want.value_one, got.value_one);
			report("value_two", want.value_two, got.value_two);
			report("value_three", 32'(want.value_three), 32'(got.value_three));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [BYTE_W-1:0] in_byte;
	logic out_valid;
	logic out_ready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0] value_one;
	logic [VAL_W-1:0] value_two;
	logic [BYTE_W-1:0] value_three;
	logic cfg_valid;
	logic cfg_ready;
	logic [BYTE_W-1:0] cfg_data;

	sentence_scoreboard sb = new();
	bit calm = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int stall_left = 0;
	logic [7:0] max_setting = MAX_PAYLOAD_RST;

	checksummed_sentence_parser dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic byte_list_t to_bytes(string s);
		byte_list_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? "0" + 8'(n) : "a" + 8'(n) - 8'd10;
	endfunction

	task automatic send_byte(input logic [7:0] c);
		if (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		in_byte <= c;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(c);
		bytes_sent++;
	endtask

	task automatic send_frame(input byte_list_t body, input flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] junk;
		logic [4:0] h;
		sum = '0;
		foreach (body[i])
			sum ^= body[i];
		send_byte(CH_START);
		if (flaw == CUT_SHORT) begin
			// Drop the tail: the next start byte lands inside this payload.
			for (int i = 0; i < body.size() / 2; i++)
				send_byte(body[i]);
			return;
		end
		foreach (body[i])
			send_byte(body[i]);
		send_byte(CH_STAR);
		if (flaw == WRONG_SUM)
			sum ^= 8'($urandom_range(1, 255));
		hi = hex_char(sum[7:4]);
		lo = hex_char(sum[3:0]);
		if ($urandom_range(1)) begin
			junk = "A" + 8'($urandom_range(5));
		end else begin
			do begin
				junk = 8'($urandom_range(255));
				h = sb.hex_digit(junk);
			end while (!h[4]);
		end
		if (flaw == BAD_SUM_HIGH)
			hi = junk;
		if (flaw == BAD_SUM_LOW)
			lo = junk;
		send_byte(hi);
		send_byte(lo);
		if (flaw == NO_NEWLINE) begin
			do junk = 8'($urandom_range(255)); while (junk == CH_NL);
			send_byte(junk);
		end else begin
			send_byte(CH_NL);
		end
	endtask

	task automatic send_random_sentence();
		byte_list_t body;
		int n_tok;
		int len;
		int r;
		logic [7:0] c;
		string junk = ".-eE x$+";
		flaw_t flaw;
		if ($urandom_range(99) < 8)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
		case ($urandom_range(9))
			0, 1: body = to_bytes("CHA");
			2, 3: body = to_bytes("HIT");
			4, 5: body = to_bytes("DET");
			6, 7: body = to_bytes("COO");
			8: repeat (3) body.push_back(8'($urandom_range(65, 90)));
			default: repeat ($urandom_range(2)) body.push_back(8'($urandom_range(65, 90)));
		endcase
		n_tok = $urandom_range(5);
		for (int t = 0; t < n_tok; t++) begin
			repeat (($urandom_range(7) == 0) ? $urandom_range(2, 3) : 1)
				body.push_back(CH_COMMA);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					// Long runs push the value into saturation.
					len = ($urandom_range(7) == 0) ? $urandom_range(10, 14)
						: $urandom_range(1, 10);
					repeat (len) body.push_back("0" + 8'($urandom_range(9)));
				end
				6: begin
					repeat ($urandom_range(1, 4)) body.push_back("0" + 8'($urandom_range(9)));
					body.push_back(junk[$urandom_range(junk.len() - 1)]);
					repeat ($urandom_range(2)) body.push_back("0" + 8'($urandom_range(9)));
				end
				7: ;
				8: begin
					repeat ($urandom_range(1, 4)) begin
						do c = 8'($urandom_range(255)); while (c == CH_STAR);
						body.push_back(c);
					end
				end
				default: begin
					body.push_back(junk[$urandom_range(junk.len() - 1)]);
					repeat ($urandom_range(1, 3)) body.push_back("0" + 8'($urandom_range(9)));
				end
			endcase
		end
		if ($urandom_range(9) == 0)
			body.push_back(CH_COMMA);
		// Land on either side of the payload limit now and then.
		if ($urandom_range(19) == 0) begin
			len = int'(max_setting) + $urandom_range(2) - 1;
			while (body.size() < len)
				body.push_back($urandom_range(1) ? "0" + 8'($urandom_range(9))
					: "a" + 8'($urandom_range(25)));
		end
		r = $urandom_range(99);
		if (r < 80)
			flaw = CLEAN;
		else if (r < 84)
			flaw = BAD_SUM_HIGH;
		else if (r < 88)
			flaw = BAD_SUM_LOW;
		else if (r < 92)
			flaw = WRONG_SUM;
		else if (r < 96)
			flaw = NO_NEWLINE;
		else
			flaw = CUT_SHORT;
		send_frame(body, flaw);
	endtask

	task automatic run_random(input int n);
		int stop;
		stop = bytes_sent + n;
		while (bytes_sent < stop)
			send_random_sentence();
	endtask

	task automatic write_max(input logic [7:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.max_len = v;
		max_setting = v;
	endtask

	// Receiver: check every accepted result, stall at random and twice for a long stretch.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				sb.check_result({status, value_one, value_two, value_three});
				results_seen++;
				if (results_seen == 900 || results_seen == 1500)
					stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin
		byte_list_t body;
		int guard;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hff);
		send_frame(to_bytes("CHA,4294967295,4294967296"), CLEAN);
		send_frame(to_bytes("HIT,,3,,,7,1,99"), CLEAN);
		send_frame(to_bytes("DET,12x5,$8"), CLEAN);
		send_frame(to_bytes("COO,300,513,"), CLEAN);
		send_frame(to_bytes("C"), CLEAN);
		send_frame(to_bytes("XYZ,1"), CLEAN);
		send_frame(to_bytes("CHA,1"), BAD_SUM_HIGH);
		send_frame(to_bytes("HIT,2"), BAD_SUM_LOW);
		send_frame(to_bytes("DET,3"), WRONG_SUM);
		send_frame(to_bytes("COO,4"), NO_NEWLINE);
		// One byte past the reset limit.
		body = to_bytes("COO,");
		repeat (61) body.push_back("1");
		send_frame(body, CLEAN);

		write_max(8'd255);
		calm = 1;
		run_random(250);
		calm = 0;
		run_random(450);
		write_max(8'd1);
		run_random(100);
		write_max(8'($urandom_range(2, 20)));
		run_random(300);
		write_max(MAX_PAYLOAD_RST);
		run_random(700);
		in_valid <= 1'b0;

		guard = 0;
		while (sb.pending() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			$display("testbench: FAIL");
		end else begin
			repeat (10) @(posedge clk);
			if (sb.mismatches == 0)
				$display("testbench: PASS");
			else
				$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/csp_pkg.sv
src/csp_dec_acc.sv
src/csp_core.sv
src/checksummed_sentence_parser.sv
tb/sv/testbench.sv
